@@ hw/rtl/sssd_pkg.sv @@
package sssd_pkg;

	// number of decimal digits on the display chain
	localparam int unsigned DIGIT_COUNT = 4;

	localparam int unsigned VALUE_W     = 14;
	localparam int unsigned SEG_W       = 8;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned TOTAL_BITS  = DIGIT_COUNT * SEG_W;
	localparam int unsigned BIT_CNT_W   = $clog2(TOTAL_BITS);
	localparam int unsigned DIGIT_CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	// x / 10 == (x * 52429) >> 19, exact for every 16-bit x
	localparam int unsigned RECIP_W     = 16;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
	localparam int unsigned RECIP_SHIFT = 19;
	localparam int unsigned PROD_W      = VALUE_W + RECIP_W;

	// pattern for a code that is not a decimal digit: all segments off
	localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

	function automatic int unsigned calc_limit(input int unsigned digits);
		int unsigned lim;
		lim = 1;
		for (int unsigned i = 0; i < digits && i < 9; i++) begin
			lim = lim * 10;
		end
		return lim - 1;
	endfunction

	// largest number the display can show
	localparam int unsigned DISPLAY_LIMIT = calc_limit(DIGIT_COUNT);

	// active-low segment patterns, decimal point bit 0 for every digit
	function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] seg;
		unique case (digit)
			4'd0: seg = 8'h40;
			4'd1: seg = 8'h79;
			4'd2: seg = 8'h24;
			4'd3: seg = 8'h30;
			4'd4: seg = 8'h19;
			4'd5: seg = 8'h12;
			4'd6: seg = 8'h02;
			4'd7: seg = 8'h78;
			4'd8: seg = 8'h00;
			4'd9: seg = 8'h10;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic load;
		logic convert;
		logic shift;
	} dp_cmd_t;

	typedef struct packed {
		logic last_digit;
		logic last_bit;
	} dp_status_t;

endpackage

@@ hw/rtl/sssd_datapath.sv @@
module sssd_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sssd_pkg::dp_cmd_t                    cmd,
	input  logic [sssd_pkg::VALUE_W-1:0]         value,
	output sssd_pkg::dp_status_t                 status,
	output logic                                 serial_bit
);

	logic [sssd_pkg::VALUE_W-1:0]     value_q;
	logic [sssd_pkg::VALUE_W-1:0]     value_sat;
	logic [sssd_pkg::TOTAL_BITS-1:0]  shift_q;
	logic [sssd_pkg::DIGIT_CNT_W-1:0] digit_cnt_q;
	logic [sssd_pkg::BIT_CNT_W-1:0]   bit_cnt_q;
	logic [sssd_pkg::PROD_W-1:0]      prod;
	logic [sssd_pkg::VALUE_W-1:0]     quot;
	logic [sssd_pkg::VALUE_W-1:0]     rem_wide;
	logic [sssd_pkg::DIGIT_W-1:0]     digit;
	logic [sssd_pkg::SEG_W-1:0]       seg;

	// clamp to the display range
	assign value_sat = (32'(value) > 32'(sssd_pkg::DISPLAY_LIMIT))
		? sssd_pkg::VALUE_W'(sssd_pkg::DISPLAY_LIMIT) : value;

	// divide by ten through the reciprocal
	assign prod     = sssd_pkg::PROD_W'(value_q) * sssd_pkg::PROD_W'(sssd_pkg::RECIP_TEN);
	assign quot     = sssd_pkg::VALUE_W'(prod[sssd_pkg::PROD_W-1:sssd_pkg::RECIP_SHIFT]);
	assign rem_wide = value_q - sssd_pkg::VALUE_W'(quot * sssd_pkg::VALUE_W'(10));
	assign digit    = rem_wide[sssd_pkg::DIGIT_W-1:0];
	assign seg      = sssd_pkg::seg_lookup(digit);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value_sat;
		end else if (cmd.convert) begin
			value_q <= quot;
		end
		// ones byte ends up on top, first out
		if (cmd.convert) begin
			shift_q <= (shift_q << sssd_pkg::SEG_W) | sssd_pkg::TOTAL_BITS'(seg);
		end else if (cmd.shift) begin
			shift_q <= shift_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_cnt_q <= '0;
			bit_cnt_q   <= '0;
		end else if (cmd.load) begin
			digit_cnt_q <= '0;
			bit_cnt_q   <= '0;
		end else begin
			if (cmd.convert) begin
				digit_cnt_q <= digit_cnt_q + 1'b1;
			end
			if (cmd.shift) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
		end
	end

	assign status.last_digit = (digit_cnt_q == sssd_pkg::DIGIT_CNT_W'(sssd_pkg::DIGIT_COUNT - 1));
	assign status.last_bit   = (bit_cnt_q == sssd_pkg::BIT_CNT_W'(sssd_pkg::TOTAL_BITS - 1));
	assign serial_bit        = shift_q[sssd_pkg::TOTAL_BITS-1];

endmodule

@@ hw/rtl/sssd_ctrl.sv @@
module sssd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 value_valid,
	input  logic                 bit_ready,
	input  sssd_pkg::dp_status_t status,
	output sssd_pkg::dp_cmd_t    cmd,
	output logic                 value_ready,
	output logic                 bit_valid
);

	sssd_pkg::state_t state_q;
	sssd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sssd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		value_ready = 1'b0;
		bit_valid   = 1'b0;
		unique case (state_q)
			sssd_pkg::ST_IDLE: begin
				value_ready = 1'b1;
				if (value_valid) begin
					cmd.load = 1'b1;
					state_d  = sssd_pkg::ST_CONVERT;
				end
			end
			sssd_pkg::ST_CONVERT: begin
				cmd.convert = 1'b1;
				if (status.last_digit) begin
					state_d = sssd_pkg::ST_SHIFT;
				end
			end
			sssd_pkg::ST_SHIFT: begin
				bit_valid = 1'b1;
				if (bit_ready) begin
					cmd.shift = 1'b1;
					if (status.last_bit) begin
						state_d = sssd_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sssd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/seven_segment_shift_out_display.sv @@
// channel   handshake               payload                   direction
// value     value_valid/ready       value[13:0]               in
// bit       bit_valid/ready         serial_bit, latch_pulse   out
//
// one value is loaded, converted and fully shifted out before the next value is taken
// the digit loop peels one decimal digit a cycle through a shared divide-by-ten unit
// the bit loop then presents one serial bit per cycle from the segment shift register while bit_ready is high
// a stalled bit transfer holds the current bit and latch strobe until taken
// reset clears the controller and counters only, no clearing pass
module seven_segment_shift_out_display (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         value_valid,
	output logic                         value_ready,
	input  logic [sssd_pkg::VALUE_W-1:0] value,
	output logic                         bit_valid,
	input  logic                         bit_ready,
	output logic                         serial_bit,
	output logic                         latch_pulse
);

	sssd_pkg::dp_cmd_t    cmd;
	sssd_pkg::dp_status_t status;

	// sequencer: idle, digit conversion, serial shift-out
	sssd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.bit_ready   (bit_ready),
		.status      (status),
		.cmd         (cmd),
		.value_ready (value_ready),
		.bit_valid   (bit_valid)
	);

	// saturation, digit split, segment lookup and shift register
	sssd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.status     (status),
		.serial_bit (serial_bit)
	);

	// latch strobe rides along with the final bit only
	assign latch_pulse = bit_valid & status.last_bit;

`ifndef SYNTHESIS
	// no new value while bits of the previous one are pending
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		bit_valid |-> !value_ready)
		else $error("value accepted during shift-out");

	// no bit is shown in the cycle after a value transfer: conversion comes first
	a_convert_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(value_valid && value_ready) |=> !bit_valid)
		else $error("bits shown before conversion");

	// the latch transfer ends the frame
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_valid && bit_ready && latch_pulse) |=> (!bit_valid && value_ready))
		else $error("shift-out continued past latch strobe");

	// a shift command only comes with a bit transfer
	a_shift_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (bit_valid && bit_ready && !cmd.convert && !cmd.load))
		else $error("datapath shifted without a bit transfer");
`endif

endmodule

@@ verif/sssd_bit_checker.sv @@
`timescale 1ns / 100ps

module sssd_bit_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         value_valid,
	input  logic                         value_ready,
	input  logic [sssd_pkg::VALUE_W-1:0] value,
	input  logic                         bit_valid,
	input  logic                         bit_ready,
	input  logic                         serial_bit,
	input  logic                         latch_pulse,
	output int                           mismatches,
	output int                           bits_pending,
	output int                           bits_checked,
	output int                           values_taken,
	output int                           values_clipped
);

	typedef struct packed {
		logic serial;
		logic latch;
	} shifted_bit_t;

	shifted_bit_t expected_bits [$];

	// active-low patterns, decimal point bit 0
	logic [sssd_pkg::SEG_W-1:0] active_low_digit [10] = '{
		8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78, 8'h00, 8'h10
	};

	function automatic int unsigned display_max();
		int unsigned lim;
		lim = 1;
		for (int i = 0; i < sssd_pkg::DIGIT_COUNT && i < 9; i++) begin
			lim = lim * 10;
		end
		return lim - 1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns  mismatch: %s", $time, what);
		mismatches++;
	endtask

	// queue the serial bits of one value: ones digit first, each byte msb first
	task automatic encode_display_value(input logic [sssd_pkg::VALUE_W-1:0] v);
		int unsigned remaining;
		logic [sssd_pkg::SEG_W-1:0] seg;
		shifted_bit_t sb;
		int n;
		remaining = 32'(v);
		if (remaining > display_max()) begin
			remaining = display_max();
			values_clipped++;
		end
		n = 0;
		for (int d = 0; d < sssd_pkg::DIGIT_COUNT; d++) begin
			seg = active_low_digit[remaining % 10];
			remaining = remaining / 10;
			for (int b = sssd_pkg::SEG_W - 1; b >= 0; b--) begin
				sb.serial = seg[b];
				sb.latch  = (n == sssd_pkg::TOTAL_BITS - 1);
				expected_bits.push_back(sb);
				n++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		shifted_bit_t want;
		if (!arst_n) begin
			expected_bits.delete();
		end else begin
			if (value_valid && value_ready) begin
				values_taken++;
				encode_display_value(value);
			end
			if (bit_valid && bit_ready) begin
				if (expected_bits.size() == 0) begin
					report_mismatch($sformatf("bit transfer (serial %b latch %b) with nothing queued",
						serial_bit, latch_pulse));
				end else begin
					want = expected_bits.pop_front();
					if (serial_bit !== want.serial)
						report_mismatch($sformatf("bit %0d serial_bit %b, expected %b",
							bits_checked, serial_bit, want.serial));
					if (latch_pulse !== want.latch)
						report_mismatch($sformatf("bit %0d latch_pulse %b, expected %b",
							bits_checked, latch_pulse, want.latch));
				end
				bits_checked++;
			end
		end
		bits_pending = expected_bits.size();
	end

endmodule

@@ verif/seven_segment_shift_out_display_tb.sv @@
`timescale 1ns / 100ps

module seven_segment_shift_out_display_tb;

	// every input starts at a known level
	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         value_valid = 1'b0;
	logic [sssd_pkg::VALUE_W-1:0] value       = '0;
	logic                         bit_ready   = 1'b0;
	logic                         value_ready;
	logic                         bit_valid;
	logic                         serial_bit;
	logic                         latch_pulse;

	// idle chances in percent, only changed at a rising edge
	int send_idle_pct = 11;
	int recv_idle_pct = 45;

	// long receiver hold-off to back the block up into its input
	localparam int HOLD_CYCLES = 300;
	logic hold_go = 1'b0;
	logic hold_on = 1'b0;

	int mismatches;
	int bits_pending;
	int bits_checked;
	int values_taken;
	int values_clipped;

	// digits in every position, input bit extremes, and the saturation boundary
	int unsigned corner_values [24] = '{
		0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 100, 1000, 1234, 5678, 9012,
		8888, 4096, 8191, 9998, 9999, 10000, 10001, 16383
	};

	always #5 clk = ~clk;

	seven_segment_shift_out_display dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value       (value),
		.bit_valid   (bit_valid),
		.bit_ready   (bit_ready),
		.serial_bit  (serial_bit),
		.latch_pulse (latch_pulse)
	);

	// watches both channels, predicts the serial stream and compares
	sssd_bit_checker bit_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.value_valid    (value_valid),
		.value_ready    (value_ready),
		.value          (value),
		.bit_valid      (bit_valid),
		.bit_ready      (bit_ready),
		.serial_bit     (serial_bit),
		.latch_pulse    (latch_pulse),
		.mismatches     (mismatches),
		.bits_pending   (bits_pending),
		.bits_checked   (bits_checked),
		.values_taken   (values_taken),
		.values_clipped (values_clipped)
	);

	// receiver side: random stalls, forced off during the hold-off
	always @(negedge clk) begin
		bit_ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
	end

	// hold-off counted here; the sender keeps offering values meanwhile
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on = 1'b0;
	end

	// generous ceiling far above the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout with %0d bits still queued", bits_pending);
		$display("RESULT: ERROR");
		$finish;
	end

	// offer one value, called at a falling edge and returning at one
	task automatic send_value(input logic [sssd_pkg::VALUE_W-1:0] v);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			value_valid <= 1'b0;
			@(negedge clk);
		end
		value_valid <= 1'b1;
		value       <= v;
		do begin
			@(posedge clk);
			taken = value_ready;
			@(negedge clk);
		end while (!taken);
	endtask

	// mostly in range, a fair share above the limit, some near the edges
	function automatic logic [sssd_pkg::VALUE_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return sssd_pkg::VALUE_W'($urandom_range(9999));
		else if (roll < 75)
			return sssd_pkg::VALUE_W'($urandom_range(16383, 10000));
		else if (roll < 90)
			return sssd_pkg::VALUE_W'($urandom_range(99));
		else
			return sssd_pkg::VALUE_W'($urandom_range(10010, 9990));
	endfunction

	// change idle rates with valid low so nothing is offered twice
	task automatic set_idle_rates(input int send_pct, input int recv_pct);
		value_valid <= 1'b0;
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		@(negedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed values first
		foreach (corner_values[i]) begin
			send_value(sssd_pkg::VALUE_W'(corner_values[i]));
		end

		// random values through three idle regimes
		for (int i = 0; i < 190; i++) begin
			if (i == 20)
				hold_go <= 1'b1;
			if (i == 65)
				set_idle_rates(45, 11);
			if (i == 130)
				set_idle_rates(0, 0);
			send_value(pick_value());
		end
		value_valid <= 1'b0;

		// drain, then allow more than one full conversion worth of quiet cycles
		while (bits_pending != 0) @(negedge clk);
		repeat (1 + sssd_pkg::DIGIT_COUNT + sssd_pkg::TOTAL_BITS + 8) @(negedge clk);

		$display("covered %0d values (%0d clipped to the display limit), %0d serial bits checked",
			values_taken, values_clipped, bits_checked);
		$display("under sender and receiver idling and a %0d-cycle receiver hold-off",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
